// ===== src/bdrm_pkg.sv =====
// Shared types and constants for the block-decomposed range minimum core.
// No dependencies; imported by block_decomposed_range_minimum_core.
package bdrm_pkg;

	localparam int IDX_W  = 10;
	localparam int DATA_W = 32;

	localparam logic signed [DATA_W-1:0] SENTINEL = 32'sh7FFF_FFFF;

	typedef enum logic {
		ACT_ASSIGN = 1'b0,
		ACT_QUERY  = 1'b1
	} action_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SPLIT,
		ST_BOUND,
		ST_SCAN_A,
		ST_SCAN_B,
		ST_SCAN_BLK,
		ST_DRAIN,
		ST_DONE
	} state_t;

endpackage

// ===== src/block_decomposed_range_minimum_core.sv =====
// Range minimum over a table split into blocks, one stored minimum per block.
// After reset a clearing pass walks every table position and fills both memories with the
// maximum value; no beat is accepted until it ends. One item is worked at a time.
// Assign: block index, then a scan of its block and a refreshed block minimum, no result;
// an index off the table is dropped. Query: block indexes, both partial blocks, middle blocks,
// bounded by the one-read-per-cycle port of each memory; an empty range skips the scan.
module block_decomposed_range_minimum_core
	import bdrm_pkg::*;
#(
	parameter int TABLE_DEPTH = 1024,
	parameter int BLOCK_SIZE  = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	output logic                     item_stall,
	input  logic                     action,
	input  logic [IDX_W-1:0]         first_index,
	input  logic [IDX_W-1:0]         last_index,
	input  logic signed [DATA_W-1:0] new_value,
	output logic                     result_valid,
	input  logic                     result_stall,
	output logic signed [DATA_W-1:0] range_minimum
);

	localparam int BLK_COUNT = (TABLE_DEPTH + BLOCK_SIZE - 1) / BLOCK_SIZE;
	localparam int ADDR_W    = $clog2(TABLE_DEPTH);
	localparam int BLK_W     = (BLK_COUNT > 1) ? $clog2(BLK_COUNT) : 1;
	localparam int REM_W     = $clog2(BLOCK_SIZE);
	localparam int LAST_POS  = (TABLE_DEPTH < (1 << IDX_W)) ? TABLE_DEPTH - 1
	                                                        : (1 << IDX_W) - 1;
	// Scaled reciprocal of the block size; exact for every index of IDX_W bits.
	localparam int RCP_SH    = IDX_W + REM_W;
	localparam int PROD_W    = RCP_SH + IDX_W;
	localparam logic [PROD_W-1:0] RCP_MUL =
		PROD_W'(((1 << RCP_SH) + BLOCK_SIZE - 1) / BLOCK_SIZE);
	localparam logic [IDX_W-1:0]  BLK_SPAN = IDX_W'(BLOCK_SIZE);

	logic signed [DATA_W-1:0] elem_mem [TABLE_DEPTH];
	logic signed [DATA_W-1:0] blk_mem  [BLK_COUNT];

	state_t state_q, state_d;

	logic                     accept;
	logic                     in_range;
	logic                     empty_range;
	logic [IDX_W-1:0]         hi_eff;

	logic [ADDR_W-1:0]        clr_ptr_q;
	logic                     clr_last;

	logic                     is_query_q;
	logic [IDX_W-1:0]         lo_q, hi_q;
	logic [IDX_W-1:0]         ptr_q, end_a_q, start_b_q;
	logic [BLK_W-1:0]         lb_q, hb_q, blk_ptr_q, blk_end_q;
	logic signed [DATA_W-1:0] min_q, min_d, min_e;
	logic signed [DATA_W-1:0] result_q;
	logic                     result_valid_q;
	logic                     result_load;

	logic [PROD_W-1:0]        lo_prod, hi_prod;
	logic [IDX_W-1:0]         lo_base, hi_base;

	logic [IDX_W:0]           blk_end_sum;
	logic [IDX_W-1:0]         blk_end_pos;

	logic                     elem_vld_s1, blk_vld_s1;
	logic signed [DATA_W-1:0] elem_rd_s1, blk_rd_s1;

	logic                     elem_we;
	logic [ADDR_W-1:0]        elem_waddr;
	logic signed [DATA_W-1:0] elem_wdata;
	logic                     blk_we;
	logic [BLK_W-1:0]         blk_waddr;
	logic signed [DATA_W-1:0] blk_wdata;

	assign item_stall    = (state_q != ST_IDLE);
	assign accept        = item_valid && !item_stall;
	assign result_valid  = result_valid_q;
	assign range_minimum = result_q;

	assign in_range    = ({{(32-IDX_W){1'b0}}, first_index} < 32'(TABLE_DEPTH));
	assign hi_eff      = ({{(32-IDX_W){1'b0}}, last_index} >= 32'(TABLE_DEPTH))
	                     ? IDX_W'(TABLE_DEPTH - 1) : last_index;
	assign empty_range = !in_range || (first_index > hi_eff);
	assign clr_last    = (clr_ptr_q == ADDR_W'(TABLE_DEPTH - 1));

	// Block indexes come from a reciprocal multiply, block starts from a constant multiply.
	assign lo_prod = PROD_W'(lo_q) * RCP_MUL;
	assign hi_prod = PROD_W'(hi_q) * RCP_MUL;
	assign lo_base = IDX_W'(lb_q) * BLK_SPAN;
	assign hi_base = IDX_W'(hb_q) * BLK_SPAN;

	// Span of the block holding the assigned position, cut at the last reachable entry.
	assign blk_end_sum = {1'b0, lo_base} + (IDX_W+1)'(BLOCK_SIZE - 1);
	assign blk_end_pos = (blk_end_sum > (IDX_W+1)'(LAST_POS)) ? IDX_W'(LAST_POS)
	                                                          : blk_end_sum[IDX_W-1:0];

	always_comb begin
		min_e = min_q;
		if (elem_vld_s1 && (elem_rd_s1 < min_q)) begin
			min_e = elem_rd_s1;
		end
		min_d = min_e;
		if (blk_vld_s1 && (blk_rd_s1 < min_e)) begin
			min_d = blk_rd_s1;
		end
		// Every item starts its search from the sentinel.
		if (state_q == ST_IDLE) begin
			min_d = SENTINEL;
		end
	end

	assign result_load = (state_q == ST_DONE) && is_query_q
	                     && (!result_valid_q || !result_stall);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					if (action == ACT_ASSIGN) begin
						state_d = in_range ? ST_SPLIT : ST_IDLE;
					end else begin
						state_d = empty_range ? ST_DONE : ST_SPLIT;
					end
				end
			end
			ST_SPLIT: begin
				state_d = ST_BOUND;
			end
			ST_BOUND: begin
				state_d = ST_SCAN_A;
			end
			ST_SCAN_A: begin
				if (ptr_q == end_a_q) begin
					state_d = (is_query_q && (lb_q != hb_q)) ? ST_SCAN_B : ST_DRAIN;
				end
			end
			ST_SCAN_B: begin
				if (ptr_q == hi_q) begin
					state_d = ({1'b0, hb_q} > ({1'b0, lb_q} + (BLK_W+1)'(1)))
					          ? ST_SCAN_BLK : ST_DRAIN;
				end
			end
			ST_SCAN_BLK: begin
				if (blk_ptr_q == blk_end_q) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!is_query_q || result_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_ptr_q      <= '0;
			result_valid_q <= 1'b0;
			elem_vld_s1    <= 1'b0;
			blk_vld_s1     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_ptr_q <= clr_ptr_q + ADDR_W'(1);
			end
			if (result_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			elem_vld_s1 <= (state_q == ST_SCAN_A) || (state_q == ST_SCAN_B);
			blk_vld_s1  <= (state_q == ST_SCAN_BLK);
		end
	end

	always_ff @(posedge clk) begin
		min_q <= min_d;
		if (result_load) begin
			result_q <= min_q;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					is_query_q <= (action == ACT_QUERY);
					lo_q       <= first_index;
					hi_q       <= hi_eff;
				end
			end
			ST_SPLIT: begin
				lb_q <= BLK_W'(lo_prod[RCP_SH +: IDX_W]);
				hb_q <= BLK_W'(hi_prod[RCP_SH +: IDX_W]);
			end
			ST_BOUND: begin
				if (is_query_q) begin
					ptr_q     <= lo_q;
					// A range inside one block scans straight to its end.
					end_a_q   <= (lb_q == hb_q) ? hi_q : lo_base + IDX_W'(BLOCK_SIZE - 1);
					start_b_q <= hi_base;
					blk_ptr_q <= lb_q + BLK_W'(1);
					blk_end_q <= hb_q - BLK_W'(1);
				end else begin
					ptr_q   <= lo_base;
					end_a_q <= blk_end_pos;
				end
			end
			ST_SCAN_A: begin
				ptr_q <= (ptr_q == end_a_q) ? start_b_q : ptr_q + IDX_W'(1);
			end
			ST_SCAN_B: begin
				ptr_q <= ptr_q + IDX_W'(1);
			end
			ST_SCAN_BLK: begin
				blk_ptr_q <= blk_ptr_q + BLK_W'(1);
			end
			ST_CLEAR, ST_DRAIN, ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// Write ports: the clearing pass, an assigned value, a refreshed block minimum.
	always_comb begin
		elem_we    = 1'b0;
		elem_waddr = ADDR_W'(first_index);
		elem_wdata = new_value;
		blk_we     = 1'b0;
		blk_waddr  = lb_q;
		blk_wdata  = min_q;
		if (state_q == ST_CLEAR) begin
			elem_we    = 1'b1;
			elem_waddr = clr_ptr_q;
			elem_wdata = SENTINEL;
			blk_we     = ({{(32-ADDR_W){1'b0}}, clr_ptr_q} < 32'(BLK_COUNT));
			blk_waddr  = BLK_W'(clr_ptr_q);
			blk_wdata  = SENTINEL;
		end else begin
			elem_we = accept && (action == ACT_ASSIGN) && in_range;
			blk_we  = (state_q == ST_DONE) && !is_query_q;
		end
	end

	always_ff @(posedge clk) begin
		if (elem_we) begin
			elem_mem[elem_waddr] <= elem_wdata;
		end
		elem_rd_s1 <= elem_mem[ADDR_W'(ptr_q)];
	end

	always_ff @(posedge clk) begin
		if (blk_we) begin
			blk_mem[blk_waddr] <= blk_wdata;
		end
		blk_rd_s1 <= blk_mem[blk_ptr_q];
	end

endmodule
